// ----- rtl/core/olsu_pkg.sv -----
`default_nettype none
package olsu_pkg;

	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	localparam logic [CNT_W-1:0] CAP_CNT = CAPACITY[CNT_W-1:0];

	typedef logic [VALUE_BITS-1:0] word_t;
	typedef logic [CAPACITY-1:0][VALUE_BITS-1:0] word_vec_t;

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_GET    = 3'd2,
		OP_SET    = 3'd3,
		OP_REMOVE = 3'd4,
		OP_FIND   = 3'd5,
		OP_CLEAR  = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// per-cycle action broadcast to every cell of the chain
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_WRITE,
		ACT_INSERT,
		ACT_REMOVE,
		ACT_CLEAR
	} act_t;

	typedef struct packed {
		act_t             act;
		logic [IDX_W-1:0] idx;
		logic [CNT_W-1:0] count;
		word_t            value;
	} cell_cmd_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [IDX_W-1:0] index;
		logic [31:0]      value;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [31:0]      read_data;
		logic             found;
		logic [IDX_W-1:0] found_index;
		logic [CNT_W-1:0] length;
	} rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/olsu_cell.sv -----
`default_nettype none
module olsu_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [olsu_pkg::IDX_W-1:0] pos,
	input  wire olsu_pkg::cell_cmd_t        cmd,
	input  wire olsu_pkg::word_t            left_word,
	input  wire olsu_pkg::word_t            right_word,
	output olsu_pkg::word_t                 word,
	output logic                            match
);

	olsu_pkg::word_t word_q;
	logic [olsu_pkg::CNT_W-1:0] pos_ext;

	assign pos_ext = {{(olsu_pkg::CNT_W - olsu_pkg::IDX_W){1'b0}}, pos};
	assign word    = word_q;
	// only live entries may match
	assign match   = (word_q == cmd.value) && (pos_ext < cmd.count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			unique case (cmd.act)
				olsu_pkg::ACT_WRITE: begin
					if (pos == cmd.idx) word_q <= cmd.value;
				end
				olsu_pkg::ACT_INSERT: begin
					if (pos == cmd.idx) begin
						word_q <= cmd.value;
					end else if (pos > cmd.idx && pos_ext <= cmd.count) begin
						word_q <= left_word;
					end
				end
				olsu_pkg::ACT_REMOVE: begin
					// take the right neighbor; the slot past the end is zero
					if (pos >= cmd.idx && pos_ext < cmd.count) word_q <= right_word;
				end
				olsu_pkg::ACT_CLEAR: begin
					word_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/olsu_chain.sv -----
`default_nettype none
module olsu_chain (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire olsu_pkg::cell_cmd_t         cmd,
	input  wire logic [olsu_pkg::IDX_W-1:0] rd_idx,
	output olsu_pkg::word_t                  rd_word,
	output logic                             found,
	output logic [olsu_pkg::IDX_W-1:0]       found_idx
);

	olsu_pkg::word_vec_t              words;
	logic [olsu_pkg::CAPACITY-1:0]    hits;

	for (genvar g = 0; g < olsu_pkg::CAPACITY; g++) begin : g_cell
		olsu_pkg::word_t lw;
		olsu_pkg::word_t rw;

		if (g == 0) begin : g_first
			assign lw = '0;
		end else begin : g_mid_l
			assign lw = words[g-1];
		end
		if (g == olsu_pkg::CAPACITY - 1) begin : g_last
			assign rw = '0;
		end else begin : g_mid_r
			assign rw = words[g+1];
		end

		olsu_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.pos        (g[olsu_pkg::IDX_W-1:0]),
			.cmd        (cmd),
			.left_word  (lw),
			.right_word (rw),
			.word       (words[g]),
			.match      (hits[g])
		);
	end

	assign rd_word = words[rd_idx];

	// lowest matching position wins
	always_comb begin
		found     = |hits;
		found_idx = '0;
		for (int i = olsu_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (hits[i]) found_idx = i[olsu_pkg::IDX_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/ordered_list_store_unit.sv -----
`default_nettype none
// Ordered list of up to 16 words held in a row of cells, one word per cell.
// Request channel (req_valid/req_ready/req) carries one word per operation:
// append, insert, get, set, remove, find or clear. Response channel
// (rsp_valid/rsp_ready/rsp) returns exactly one word per request with the
// status, the word read, the find result and the length after the operation.
// All cells carry out an operation at once: they shift, load or compare
// side by side, and the response appears in the output register on the
// cycle after the request is taken. Throughput is one request per cycle
// while rsp_ready stays high. req_ready is high when the output register
// is empty or is being drained in the same cycle. A stalled receiver holds
// the response in the register and drops req_ready at once, so the sender
// waits until that word is taken; nothing is dropped or repeated.
// Reset clears every cell to zero, the length to zero and the response valid
// flag, so the list is empty and usable on the first cycle after reset.
// Slots at or past the length always hold zero.
module ordered_list_store_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire olsu_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output olsu_pkg::rsp_t     rsp
);

	logic [olsu_pkg::CNT_W-1:0] count_q;
	logic                       rsp_valid_q;
	olsu_pkg::rsp_t             rsp_q;

	logic                       take;
	logic [olsu_pkg::CNT_W-1:0] idx_ext;
	logic                       full;
	olsu_pkg::act_t             act;
	logic [olsu_pkg::IDX_W-1:0] act_idx;
	logic [olsu_pkg::CNT_W-1:0] count_nxt;
	olsu_pkg::status_t          status;
	logic                       do_read;
	logic                       do_find;
	olsu_pkg::cell_cmd_t        cmd;
	olsu_pkg::word_t            rd_word;
	logic                       hit;
	logic [olsu_pkg::IDX_W-1:0] hit_idx;
	logic [31:0]                rd_data;
	olsu_pkg::rsp_t             rsp_nxt;

	// accept while the output register is free or draining
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign take      = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign idx_ext = {{(olsu_pkg::CNT_W - olsu_pkg::IDX_W){1'b0}}, req.index};
	assign full    = count_q >= olsu_pkg::CAP_CNT;

	// decode the operation against the current length
	always_comb begin
		act       = olsu_pkg::ACT_NONE;
		act_idx   = req.index;
		count_nxt = count_q;
		status    = olsu_pkg::ST_OK;
		do_read   = 1'b0;
		do_find   = 1'b0;
		unique case (req.op)
			olsu_pkg::OP_APPEND: begin
				if (full) begin
					status = olsu_pkg::ST_FULL;
				end else begin
					act       = olsu_pkg::ACT_WRITE;
					act_idx   = count_q[olsu_pkg::IDX_W-1:0];
					count_nxt = count_q + 1'b1;
				end
			end
			olsu_pkg::OP_INSERT: begin
				// index check comes before the full check
				if (idx_ext > count_q) begin
					status = olsu_pkg::ST_BAD_INDEX;
				end else if (full) begin
					status = olsu_pkg::ST_FULL;
				end else begin
					act       = olsu_pkg::ACT_INSERT;
					count_nxt = count_q + 1'b1;
				end
			end
			olsu_pkg::OP_GET: begin
				if (idx_ext >= olsu_pkg::CAP_CNT) begin
					status = olsu_pkg::ST_BAD_INDEX;
				end else begin
					do_read = idx_ext < count_q;
				end
			end
			olsu_pkg::OP_SET: begin
				if (idx_ext >= count_q) begin
					status = olsu_pkg::ST_BAD_INDEX;
				end else begin
					act = olsu_pkg::ACT_WRITE;
				end
			end
			olsu_pkg::OP_REMOVE: begin
				if (idx_ext >= count_q) begin
					status = olsu_pkg::ST_BAD_INDEX;
				end else begin
					act       = olsu_pkg::ACT_REMOVE;
					count_nxt = count_q - 1'b1;
				end
			end
			olsu_pkg::OP_FIND: begin
				do_find = 1'b1;
			end
			olsu_pkg::OP_CLEAR: begin
				act       = olsu_pkg::ACT_CLEAR;
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	// broadcast to the cells only on an accepted word
	always_comb begin
		cmd.act   = take ? act : olsu_pkg::ACT_NONE;
		cmd.idx   = act_idx;
		cmd.count = count_q;
		cmd.value = req.value[olsu_pkg::VALUE_BITS-1:0];
	end

	olsu_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_idx    (req.index),
		.rd_word   (rd_word),
		.found     (hit),
		.found_idx (hit_idx)
	);

	always_comb begin
		rd_data                             = '0;
		rd_data[olsu_pkg::VALUE_BITS-1:0]   = rd_word;
		rsp_nxt.status      = status;
		rsp_nxt.read_data   = do_read ? rd_data : '0;
		rsp_nxt.found       = do_find && hit;
		rsp_nxt.found_index = (do_find && hit) ? hit_idx : '0;
		rsp_nxt.length      = count_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the response until it is taken
	always_ff @(posedge clk) begin
		if (take) rsp_q <= rsp_nxt;
	end

endmodule
`default_nettype wire
